[rtl/dvs_pkg.sv]
`default_nettype none

package dvs_pkg;

    localparam int N_ENTRIES = 64;
    localparam int IDX_W     = $clog2(N_ENTRIES);
    localparam int CNT_W     = $clog2(N_ENTRIES + 1);
    localparam int VAL_W     = 32;

    typedef logic signed [VAL_W-1:0] value_t;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_LOOKUP = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        STS_ADDED     = 3'd0,
        STS_ALREADY   = 3'd1,
        STS_FULL      = 3'd2,
        STS_REMOVED   = 3'd3,
        STS_NOT_FOUND = 3'd4,
        STS_PRESENT   = 3'd5,
        STS_ABSENT    = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_EXEC
    } state_t;

    // Broadcast command from the controller to every cell.
    typedef struct packed {
        logic add_en;
        logic rem_en;
    } cell_cmd_t;

endpackage

`default_nettype wire

[rtl/dvs_cell.sv]
`default_nettype none

module dvs_cell (
    input  wire logic               clk,
    input  wire dvs_pkg::value_t    key,
    input  wire dvs_pkg::cell_cmd_t cmd,
    input  wire logic               write_sel,
    input  wire dvs_pkg::value_t    up_data,
    input  wire logic               seen_in,
    output logic                    seen_out,
    output dvs_pkg::value_t         entry,
    output logic                    match
);
    import dvs_pkg::*;

    value_t entry_reg;
    value_t entry_next;
    logic   match_reg;
    logic   shift_here;

    // On a remove, a cell at or above the matching one takes its upper neighbor's value.
    assign seen_out   = seen_in | match_reg;
    assign shift_here = cmd.rem_en & seen_out;

    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.add_en && write_sel)
        begin
            entry_next = key;
        end
        else if (shift_here)
        begin
            entry_next = up_data;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        match_reg <= (entry_reg == key);
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

[rtl/dvs_ctrl.sv]
`default_nettype none

module dvs_ctrl (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [31:0]                     s_axis_tdata,
    input  wire logic [1:0]                      s_axis_tuser,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [6:0]                      cfg_data,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic [15:0]                          m_axis_tdata,
    output logic [2:0]                           m_axis_tuser,
    input  wire logic [dvs_pkg::N_ENTRIES-1:0]   match_vec,
    output dvs_pkg::value_t                      key,
    output dvs_pkg::cell_cmd_t                   cmd,
    output logic [dvs_pkg::N_ENTRIES-1:0]        write_sel
);
    import dvs_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    value_t              key_reg;
    op_t                 op_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [CNT_W-1:0]    cap_reg;
    logic [CNT_W-1:0]    limit;
    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [IDX_W-1:0]    out_pos_reg;
    logic [CNT_W-1:0]    out_count_reg;

    logic [N_ENTRIES-1:0] valid_mask;
    logic [N_ENTRIES-1:0] hit;
    logic                 found;
    logic [IDX_W-1:0]     hit_pos;
    status_t              status;
    logic [IDX_W-1:0]     pos;
    logic                 add_do;
    logic                 rem_do;
    logic                 exec_go;
    logic                 in_xfer;

    assign cfg_ready = 1'b1;
    assign exec_go   = (state_reg == ST_EXEC) && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = (state_reg == ST_IDLE) || exec_go;
    assign in_xfer   = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        for (int i = 0; i < N_ENTRIES; i++)
        begin
            valid_mask[i] = (CNT_W'(i) < count_reg);
            write_sel[i]  = (CNT_W'(i) == count_reg);
        end
    end

    assign hit   = match_vec & valid_mask;
    assign found = |hit;

    // Held values are distinct, so at most one bit of hit is set.
    always_comb
    begin
        hit_pos = '0;
        for (int i = 0; i < N_ENTRIES; i++)
        begin
            if (hit[i])
            begin
                hit_pos = hit_pos | IDX_W'(i);
            end
        end
    end

    assign limit = (cap_reg > CNT_W'(N_ENTRIES)) ? CNT_W'(N_ENTRIES) : cap_reg;

    always_comb
    begin
        status     = STS_ABSENT;
        pos        = '0;
        add_do     = 1'b0;
        rem_do     = 1'b0;
        count_next = count_reg;
        case (op_reg)
            OP_ADD:
            begin
                if (found)
                begin
                    status = STS_ALREADY;
                    pos    = hit_pos;
                end
                else if (count_reg >= limit)
                begin
                    status = STS_FULL;
                end
                else
                begin
                    status     = STS_ADDED;
                    pos        = count_reg[IDX_W-1:0];
                    add_do     = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_REMOVE:
            begin
                if (found)
                begin
                    status     = STS_REMOVED;
                    pos        = hit_pos;
                    rem_do     = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                end
                else
                begin
                    status = STS_NOT_FOUND;
                end
            end
            default:
            begin
                if (found)
                begin
                    status = STS_PRESENT;
                    pos    = hit_pos;
                end
                else
                begin
                    status = STS_ABSENT;
                end
            end
        endcase
    end

    assign cmd.add_en = exec_go && add_do;
    assign cmd.rem_en = exec_go && rem_do;
    assign key        = key_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (exec_go)
                begin
                    state_next = in_xfer ? ST_CMP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cap_reg       <= CNT_W'(N_ENTRIES);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            if (exec_go)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            key_reg <= s_axis_tdata;
            op_reg  <= op_t'(s_axis_tuser);
        end
        if (exec_go)
        begin
            out_status_reg <= status;
            out_pos_reg    <= pos;
            out_count_reg  <= count_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {3'b000, out_count_reg, out_pos_reg};

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(N_ENTRIES))
        else $error("held count exceeds table size");

    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> $onehot0(hit))
        else $error("value held in more than one entry");

    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.add_en |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("add did not advance count");

    a_rem_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rem_en |-> (count_reg != '0))
        else $error("remove issued on empty set");

    a_result_follows_exec: assert property (@(posedge clk) disable iff (!rst_n)
        exec_go |=> out_valid_reg)
        else $error("result register not loaded");

endmodule

`default_nettype wire

[rtl/bounded_distinct_value_set_core.sv]
// A result is registered on m_axis after its input passes the compare state (the
// compare in the cells) and the execute state (acting on it); a new input transfer
// is taken while the last operation executes. A stalled result holds the next operation
// after its compare and blocks further input transfers until the result is taken.
// Every cell compares the key in parallel; remove shifts the upper cells down all at once.
// Reset (rst_n low, asynchronous) empties the set and sets the capacity limit to 64.
`default_nettype none

module bounded_distinct_value_set_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] operation
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [5:0] position, [12:6] count, [15:13] zero
    output logic [2:0]       m_axis_tuser    // [2:0] status
);
    import dvs_pkg::*;

    value_t               key;
    cell_cmd_t            cmd;
    logic [N_ENTRIES-1:0] write_sel;
    logic [N_ENTRIES-1:0] match_vec;
    logic [N_ENTRIES:0]   seen;
    value_t               entry_w [N_ENTRIES];

    assign seen[0] = 1'b0;

    dvs_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .match_vec     (match_vec),
        .key           (key),
        .cmd           (cmd),
        .write_sel     (write_sel)
    );

    for (genvar i = 0; i < N_ENTRIES; i++)
    begin : g_cell
        value_t up_data;

        if (i == N_ENTRIES - 1)
        begin : g_top
            assign up_data = entry_w[i];
        end
        else
        begin : g_mid
            assign up_data = entry_w[i+1];
        end

        dvs_cell u_cell (
            .clk       (clk),
            .key       (key),
            .cmd       (cmd),
            .write_sel (write_sel[i]),
            .up_data   (up_data),
            .seen_in   (seen[i]),
            .seen_out  (seen[i+1]),
            .entry     (entry_w[i]),
            .match     (match_vec[i])
        );
    end

endmodule

`default_nettype wire
